// ===== rtl/utf8d_pkg.sv =====
// ----------------------------------------------------------------------------
// utf8d_pkg
// Shared types and constants of the UTF-8 byte stream decoder.
// ----------------------------------------------------------------------------
package utf8d_pkg;

    localparam int unsigned CP_W    = 21;
    localparam int unsigned Q_DEPTH = 3;

    localparam logic [CP_W-1:0] BAD_CP = CP_W'(8'h3F);  // '?'

    localparam logic [7:0] LEAD4 = 8'hF0;
    localparam logic [7:0] LEAD3 = 8'hE0;
    localparam logic [7:0] LEAD2 = 8'hC0;
    localparam logic [7:0] CONT  = 8'h80;

    typedef struct packed {
        logic [CP_W-1:0] cp;
        logic            run_last;
        logic            string_end;
    } t_res;

    // results of one byte, compacted: res0 first, res1 second
    typedef struct packed {
        logic [1:0] cnt;
        t_res       res0;
        t_res       res1;
    } t_dec;

endpackage

// ===== rtl/utf8d_decode.sv =====
// ----------------------------------------------------------------------------
// utf8d_decode
// Sequence state and per-byte decode; yields up to two results per byte.
// ----------------------------------------------------------------------------
module utf8d_decode (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_fire,
    input  logic [7:0]      i_byte,
    input  logic            i_last,
    output utf8d_pkg::t_dec o_dec
);
    import utf8d_pkg::*;

    logic [1:0]      r_pend;
    logic [CP_W-1:0] r_part;
    logic [1:0]      n_pend;
    logic [CP_W-1:0] n_part;
    logic [CP_W-1:0] acc;
    logic [CP_W-1:0] mid_cp;
    logic            e_bad;
    logic            e_mid;
    logic            e_end;
    logic [1:0]      cnt;

    assign acc = {r_part[CP_W-7:0], i_byte[5:0]};

    always_comb begin
        n_pend = r_pend;
        n_part = r_part;
        e_bad  = 1'b0;
        e_mid  = 1'b0;
        e_end  = 1'b0;
        mid_cp = BAD_CP;
        if (r_pend != 2'd0 && i_byte[7:6] == 2'b10) begin
            n_pend = r_pend - 2'd1;
            if (n_pend == 2'd0) begin
                e_mid  = 1'b1;
                mid_cp = acc;
                n_part = '0;
            end else begin
                n_part = acc;
            end
        end else begin
            e_bad  = (r_pend != 2'd0);
            n_pend = 2'd0;
            n_part = '0;
            priority if (i_byte >= LEAD4) begin
                n_part = CP_W'(i_byte[2:0]);
                n_pend = 2'd3;
            end else if (i_byte >= LEAD3) begin
                n_part = CP_W'(i_byte[3:0]);
                n_pend = 2'd2;
            end else if (i_byte >= LEAD2) begin
                n_part = CP_W'(i_byte[4:0]);
                n_pend = 2'd1;
            end else if (i_byte >= CONT) begin
                e_mid  = 1'b1;
                mid_cp = BAD_CP;
            end else begin
                e_mid  = 1'b1;
                mid_cp = CP_W'(i_byte);
            end
        end
        if (i_last) begin
            e_end  = (n_pend != 2'd0);
            n_pend = 2'd0;
            n_part = '0;
        end
    end

    assign cnt = 2'(e_bad) + 2'(e_mid) + 2'(e_end);

    always_comb begin
        o_dec.cnt              = cnt;
        o_dec.res0.cp          = e_bad ? BAD_CP : (e_mid ? mid_cp : BAD_CP);
        o_dec.res0.run_last    = (cnt == 2'd1);
        o_dec.res0.string_end  = i_last && (cnt == 2'd1);
        o_dec.res1.cp          = (e_bad && e_mid) ? mid_cp : BAD_CP;
        o_dec.res1.run_last    = 1'b1;
        o_dec.res1.string_end  = i_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 2'd0;
            r_part <= '0;
        end else if (i_fire) begin
            r_pend <= n_pend;
            r_part <= n_part;
        end
    end

    a_max_two : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire |-> cnt != 2'd3)
        else $error("more than two results for one byte");

    a_last_clears : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && i_last |=> r_pend == 2'd0 && r_part == '0)
        else $error("sequence state survives end of string");

endmodule

// ===== rtl/utf8d_outq.sv =====
// ----------------------------------------------------------------------------
// utf8d_outq
// Three-entry result queue; takes up to two results while holding at most one.
// ----------------------------------------------------------------------------
module utf8d_outq (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  utf8d_pkg::t_dec i_dec,
    output logic            o_room,
    output logic            o_vld,
    input  logic            i_rdy,
    output utf8d_pkg::t_res o_res
);
    import utf8d_pkg::*;

    t_res       r_q [Q_DEPTH];
    t_res       n_q [Q_DEPTH];
    logic [1:0] r_cnt;
    logic [1:0] n_cnt;
    logic [1:0] c1;
    logic [1:0] pcnt;
    logic       pop;

    assign o_vld  = (r_cnt != 2'd0);
    assign o_room = (r_cnt <= 2'd1);
    assign o_res  = r_q[0];
    assign pop    = o_vld && i_rdy;
    assign c1     = r_cnt - 2'(pop);
    assign pcnt   = i_push ? i_dec.cnt : 2'd0;
    assign n_cnt  = c1 + pcnt;

    always_comb begin
        for (int i = 0; i < Q_DEPTH; i++) begin
            if (pop && i < Q_DEPTH - 1) begin
                n_q[i] = r_q[i+1];
            end else begin
                n_q[i] = r_q[i];
            end
            if (2'(i) == c1 && pcnt != 2'd0) begin
                n_q[i] = i_dec.res0;
            end else if (2'(i) == c1 + 2'd1 && pcnt == 2'd2) begin
                n_q[i] = i_dec.res1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < Q_DEPTH; i++) begin
            r_q[i] <= n_q[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    a_push_room : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> o_room)
        else $error("push into full queue");

    a_cnt_track : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_push && !pop |=> $stable(r_cnt))
        else $error("queue count moved without push or pop");

endmodule

// ===== rtl/utf8_byte_stream_decoder.sv =====
// ----------------------------------------------------------------------------
// utf8_byte_stream_decoder
// Streaming UTF-8 decoder: one byte in, zero to two code points out.
// ----------------------------------------------------------------------------
//  channel  dir  handshake               payload
//  s        in   i_s_tvalid/o_s_tready   byte, tlast = last byte of string
//  m        out  o_m_tvalid/i_m_tready   code point, tlast = run_last,
//                                        tuser = string_end
//
//  One byte per cycle while the output queue has room; a byte giving two
//  results can hold the input. Bytes pass an input register, then the
//  three-entry output queue, which sets the rate: decode runs when it holds
//  at most one word. Synchronous active-low reset empties everything.
// ----------------------------------------------------------------------------
module utf8_byte_stream_decoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] byte_req
    input  logic        i_s_tlast,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [23:0] o_m_tdata,   // [20:0] code_point, [23:21] zero
    output logic        o_m_tlast,
    output logic [0:0]  o_m_tuser    // [0] string_end
);
    import utf8d_pkg::*;

    logic       r_in_vld;
    logic [7:0] r_in_byte;
    logic       r_in_last;
    logic       room;
    logic       fire;
    t_dec       dec;
    t_res       res;

    assign fire       = r_in_vld && room;
    assign o_s_tready = !r_in_vld || fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_s_tready) begin
            r_in_vld <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_byte <= i_s_tdata;
            r_in_last <= i_s_tlast;
        end
    end

    utf8d_decode u_decode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_byte  (r_in_byte),
        .i_last  (r_in_last),
        .o_dec   (dec)
    );

    utf8d_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fire),
        .i_dec   (dec),
        .o_room  (room),
        .o_vld   (o_m_tvalid),
        .i_rdy   (i_m_tready),
        .o_res   (res)
    );

    assign o_m_tdata = {3'b000, res.cp};
    assign o_m_tlast = res.run_last;
    assign o_m_tuser = res.string_end;

    a_in_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_vld && !room |=> r_in_vld && $stable(r_in_byte) && $stable(r_in_last))
        else $error("held input byte lost");

endmodule
